FILE: sv/kmd_pkg.sv
package kmd_pkg;

  // Default geometry of the key matrix and the keymap.
  localparam int DEF_ROWS   = 8;
  localparam int DEF_COLS   = 16;
  localparam int DEF_LAYERS = 8;

  // Cooldown loaded on a press, and the number of layers a rotate tries.
  localparam logic [7:0] COOL_MAX  = 8'd255;
  localparam int         ROT_TRIES = 10;

  // Item function carried on tuser.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_MAP    = 1'b1;

  // Key kinds stored in the high byte of a keymap entry.
  localparam logic [7:0] KIND_HID    = 8'd0;
  localparam logic [7:0] KIND_FN     = 8'd1;
  localparam logic [7:0] KIND_MOVE   = 8'd2;
  localparam logic [7:0] KIND_TOGGLE = 8'd3;

  // Layer move values; any other value is a rotate bitfield.
  localparam logic [7:0] MOVE_UP   = 8'd0;
  localparam logic [7:0] MOVE_DOWN = 8'd1;

  // Event codes.
  localparam logic [1:0] RES_NONE    = 2'd0;
  localparam logic [1:0] RES_PRESS   = 2'd1;
  localparam logic [1:0] RES_RELEASE = 2'd2;

  // HID action codes.
  localparam logic [1:0] HID_NONE    = 2'd0;
  localparam logic [1:0] HID_PRESS   = 2'd1;
  localparam logic [1:0] HID_RELEASE = 2'd2;

  // Configuration register indexes (byte address is four times the index).
  localparam int         ADDR_W          = 4;
  localparam logic [1:0] REG_USB_PRESENT = 2'd0;
  localparam logic [1:0] REG_KEY_UP      = 2'd1;
  localparam logic [1:0] REG_KEY_DOWN    = 2'd2;

  // Register reset values.
  localparam logic       RST_USB_PRESENT = 1'b1;
  localparam logic [7:0] RST_KEY_UP      = 8'd5;
  localparam logic [7:0] RST_KEY_DOWN    = 8'd5;

  // Input item fields as packed on s_tdata, last field in the low bits.
  typedef struct packed {
    logic [7:0] map_kind;
    logic [7:0] map_value;
    logic [2:0] map_layer;
    logic       key_down;
    logic [3:0] col;
    logic [2:0] row;
    logic       scan_start;
  } item_t;

  localparam int ITEM_W  = $bits(item_t);
  localparam int S_TDATA_W = 32;

  // Result fields as packed on m_tdata, last field in the low bits.
  typedef struct packed {
    logic [7:0] active_layer;
    logic [2:0] main_layer;
    logic [1:0] hid_action;
    logic [3:0] event_col;
    logic [2:0] event_row;
    logic [7:0] event_kind;
    logic [7:0] event_value;
  } out_data_t;

  localparam int OUT_W     = $bits(out_data_t);
  localparam int M_TDATA_W = 40;

  // One finished result item.
  typedef struct packed {
    logic [1:0] event_res;
    out_data_t  data;
  } event_t;

  // Per-key debounce state.
  typedef struct packed {
    logic [7:0] cool;
    logic [7:0] layer;
  } key_state_t;

endpackage

FILE: sv/kmd_keymap.sv
module kmd_keymap #(
  parameter int ROWS   = kmd_pkg::DEF_ROWS,
  parameter int COLS   = kmd_pkg::DEF_COLS,
  parameter int LAYERS = kmd_pkg::DEF_LAYERS,
  localparam int NKEYS   = ROWS * COLS,
  localparam int KEY_W   = (NKEYS > 1) ? $clog2(NKEYS) : 1,
  localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [KEY_W-1:0]              wr_key,
  input  logic [LAYER_W-1:0]            wr_layer,
  input  logic [15:0]                   wr_data,
  input  logic                          rd_en,
  input  logic [KEY_W-1:0]              rd_key,
  output logic [LAYERS-1:0][15:0]       rd_row
);

  // One word per key holds the entries of all layers, so a lookup needs
  // only the key and the layer is picked after the read.
  logic [LAYERS-1:0][15:0] mem [NKEYS];

  // Write one layer lane of a key's word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_key][wr_layer] <= wr_data;
    end
  end

  // Registered read of the whole word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_key];
    end
  end

endmodule

FILE: sv/kmd_key_state.sv
module kmd_key_state #(
  parameter int ROWS = kmd_pkg::DEF_ROWS,
  parameter int COLS = kmd_pkg::DEF_COLS,
  localparam int NKEYS = ROWS * COLS,
  localparam int KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [KEY_W-1:0]    rd_key,
  input  logic                wr_en,
  input  logic [KEY_W-1:0]    wr_key,
  input  kmd_pkg::key_state_t wr_data,
  output kmd_pkg::key_state_t rd_data
);

  kmd_pkg::key_state_t mem [NKEYS];
  logic [NKEYS-1:0]    valid;

  // Store the updated state of a key; a key not yet written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_key] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_key] <= wr_data;
    end
  end

  // Registered read. The item leaving the compute stage in the same cycle
  // may update the key being read, so its new state is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_key == rd_key)) begin
        rd_data <= wr_data;
      end else if (valid[rd_key]) begin
        rd_data <= mem[rd_key];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

FILE: sv/kmd_event_unit.sv
module kmd_event_unit #(
  parameter int LAYERS = kmd_pkg::DEF_LAYERS
) (
  input  logic                    func,
  input  kmd_pkg::item_t          item,
  input  logic                    in_range,
  input  kmd_pkg::key_state_t     ks,
  input  logic [LAYERS-1:0][15:0] km_row,
  input  logic [2:0]              main_layer,
  input  logic [7:0]              active_layer,
  input  logic                    usb_present,
  input  logic [7:0]              key_up_delay,
  input  logic [7:0]              key_down_delay,
  output kmd_pkg::event_t         ev,
  output kmd_pkg::key_state_t     ks_next,
  output logic [2:0]              main_next,
  output logic [7:0]              active_next
);

  localparam int LAYER_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int ROT_SKIP = kmd_pkg::ROT_TRIES % LAYERS;

  logic [2:0]  main_s;
  logic [7:0]  active_s;
  logic [7:0]  hold;
  logic        is_press;
  logic        is_release;
  logic [7:0]  look_layer;
  logic [15:0] entry;
  logic [7:0]  ev_value;
  logic [7:0]  ev_kind;
  logic [3:0]  m4;
  logic [3:0]  step_up;
  logic [3:0]  step_down;
  logic [3:0]  rot_skip;
  logic [3:0]  rot_c;
  logic [3:0]  rot_pick;
  logic [7:0]  cool;
  logic [1:0]  res;
  logic [1:0]  hid;

  // Scan start pulls both layers back to zero when either is out of range.
  always_comb begin
    main_s   = main_layer;
    active_s = active_layer;
    if (item.scan_start && ((4'(main_layer) >= 4'(LAYERS)) ||
                            (active_layer >= 8'(LAYERS)))) begin
      main_s   = '0;
      active_s = '0;
    end
  end

  // Press and release detection against the key's cooldown.
  assign hold       = kmd_pkg::COOL_MAX - key_up_delay;
  assign is_press   = (func == kmd_pkg::FUNC_SAMPLE) && in_range && item.key_down &&
                      (ks.cool == 8'd0);
  assign is_release = (func == kmd_pkg::FUNC_SAMPLE) && in_range && !item.key_down &&
                      (ks.cool == hold);

  // Keymap lookup: a press reads the active layer, a release the recorded one.
  assign look_layer = is_press ? active_s : ks.layer;
  assign entry      = (look_layer < 8'(LAYERS)) ? km_row[look_layer[LAYER_W-1:0]] : 16'd0;
  assign ev_value   = entry[7:0];
  assign ev_kind    = entry[15:8];

  // Main layer step up and down with wrap.
  assign m4 = 4'(main_s);
  always_comb begin
    step_up = m4 + 4'd1;
    if (step_up >= 4'(LAYERS)) begin
      step_up = 4'd0;
    end
    step_down = (m4 == 4'd0) ? 4'(LAYERS - 1) : (m4 - 4'd1);
  end

  // Rotate: the first layer after the main one whose bit is set, searched
  // cyclically; with no such bit the last tried layer is kept.
  always_comb begin
    rot_skip = m4 + 4'(ROT_SKIP);
    if (rot_skip >= 4'(LAYERS)) begin
      rot_skip = rot_skip - 4'(LAYERS);
    end
    rot_pick = rot_skip;
    rot_c    = '0;
    for (int j = LAYERS; j >= 1; j--) begin
      rot_c = m4 + 4'(j);
      if (rot_c >= 4'(LAYERS)) begin
        rot_c = rot_c - 4'(LAYERS);
      end
      if (ev_value[rot_c[2:0]]) begin
        rot_pick = rot_c;
      end
    end
  end

  // Event, layer changes and key state update.
  always_comb begin
    main_next   = main_s;
    active_next = active_s;
    res         = kmd_pkg::RES_NONE;
    hid         = kmd_pkg::HID_NONE;
    cool        = ks.cool;
    ks_next     = ks;
    if (is_press) begin
      res           = kmd_pkg::RES_PRESS;
      ks_next.layer = active_s;
      cool          = kmd_pkg::COOL_MAX;
      if (usb_present) begin
        case (ev_kind)
          kmd_pkg::KIND_HID:    hid = kmd_pkg::HID_PRESS;
          kmd_pkg::KIND_FN:     active_next = ev_value;
          kmd_pkg::KIND_MOVE: begin
            if (ev_value == kmd_pkg::MOVE_UP) begin
              main_next = step_up[2:0];
            end else if (ev_value == kmd_pkg::MOVE_DOWN) begin
              main_next = step_down[2:0];
            end else begin
              main_next = rot_pick[2:0];
            end
          end
          kmd_pkg::KIND_TOGGLE: begin
            active_next = (active_s == ev_value) ? 8'(main_s) : ev_value;
          end
          default: ;
        endcase
      end
    end else if (is_release) begin
      res  = kmd_pkg::RES_RELEASE;
      cool = key_down_delay;
      if (usb_present) begin
        if (ev_kind == kmd_pkg::KIND_HID) begin
          hid = kmd_pkg::HID_RELEASE;
        end else if (ev_kind == kmd_pkg::KIND_FN) begin
          active_next = 8'(main_s);
        end
      end
    end
    // The cooldown runs down every sample except while parked at the hold value.
    if ((cool != 8'd0) && (cool != hold)) begin
      cool = cool - 8'd1;
    end
    ks_next.cool = cool;
  end

  // Result item; event fields read zero when nothing registered.
  always_comb begin
    ev                   = '0;
    ev.event_res         = res;
    ev.data.hid_action   = hid;
    ev.data.main_layer   = main_next;
    ev.data.active_layer = active_next;
    if (res != kmd_pkg::RES_NONE) begin
      ev.data.event_value = ev_value;
      ev.data.event_kind  = ev_kind;
      ev.data.event_row   = item.row;
      ev.data.event_col   = item.col;
    end
  end

endmodule

FILE: sv/key_matrix_debounce_layer_engine.sv
// Key matrix debounce and layer engine.
// Input items arrive on s_tvalid/s_tready: tuser selects a key sample (0) or
// a keymap entry write (1), and tdata carries the key position, the sampled
// level, the scan start mark and the entry to write. Every item gives exactly
// one result item on m_tvalid/m_tready: the press or release event code on
// tuser, and the event key, its entry, the HID action and both layers on tdata.
// Configuration (usb_present at 0x0, key_up_delay at 0x4, key_down_delay at
// 0x8) is written over the APB port; the user must do so only while no item
// is in flight, which the block itself does not enforce. An accepted item
// loads the event stage and the registered reads of the keymap and the
// per-key state memories; when that stage moves on, the event logic's result
// is loaded into the output register. One item is taken every cycle while
// the output does not stall; the per-key state read-modify-write keeps pace
// by forwarding the state of the item leaving the event stage to the next read.
// Reset clears the layers, restores the register defaults and marks every
// key's cooldown and recorded layer as zero at once; the keymap holds no
// defined contents until written. When the receiver stalls, the result stays
// in the output register, one more item waits in the event stage, and
// s_tready then drops until the output moves.
module key_matrix_debounce_layer_engine #(
  parameter int ROWS   = kmd_pkg::DEF_ROWS,
  parameter int COLS   = kmd_pkg::DEF_COLS,
  parameter int LAYERS = kmd_pkg::DEF_LAYERS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input items.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // scan_start[0], row[3:1], col[7:4], key_down[8], map_layer[11:9],
  // map_value[19:12], map_kind[27:20], zero fill[31:28]
  input  logic [kmd_pkg::S_TDATA_W-1:0] s_tdata,
  // func[0]
  input  logic                          s_tuser,
  // Result items.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // event_value[7:0], event_kind[15:8], event_row[18:16], event_col[22:19],
  // hid_action[24:23], main_layer[27:25], active_layer[35:28], zero fill[39:36]
  output logic [kmd_pkg::M_TDATA_W-1:0] m_tdata,
  // event_res[1:0]
  output logic [1:0]                    m_tuser,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmd_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int NKEYS   = ROWS * COLS;
  localparam int KEY_W   = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  // Configuration registers.
  logic       usb_present;
  logic [7:0] key_up_delay;
  logic [7:0] key_down_delay;
  logic [1:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      usb_present    <= kmd_pkg::RST_USB_PRESENT;
      key_up_delay   <= kmd_pkg::RST_KEY_UP;
      key_down_delay <= kmd_pkg::RST_KEY_DOWN;
    end else if (cfg_write) begin
      case (reg_index)
        kmd_pkg::REG_USB_PRESENT: usb_present    <= pwdata[0];
        kmd_pkg::REG_KEY_UP:      key_up_delay   <= pwdata[7:0];
        kmd_pkg::REG_KEY_DOWN:    key_down_delay <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      kmd_pkg::REG_USB_PRESENT: prdata = 32'(usb_present);
      kmd_pkg::REG_KEY_UP:      prdata = 32'(key_up_delay);
      kmd_pkg::REG_KEY_DOWN:    prdata = 32'(key_down_delay);
      default:                  prdata = 32'd0;
    endcase
  end

  // Input decode.
  kmd_pkg::item_t   in_item;
  logic             in_accept;
  logic             in_key_ok;
  logic             in_map_ok;
  logic [KEY_W-1:0] in_key;

  assign in_item   = kmd_pkg::item_t'(s_tdata[kmd_pkg::ITEM_W-1:0]);
  assign in_accept = s_tvalid && s_tready;
  assign in_key_ok = (5'(in_item.row) < 5'(ROWS)) && (6'(in_item.col) < 6'(COLS));
  assign in_map_ok = in_key_ok && (4'(in_item.map_layer) < 4'(LAYERS));
  assign in_key    = KEY_W'(32'(in_item.row) * 32'(COLS) + 32'(in_item.col));

  // Event stage registers.
  logic             s1_valid;
  logic             s1_func;
  kmd_pkg::item_t   s1_item;
  logic             s1_key_ok;
  logic [KEY_W-1:0] s1_key;
  logic             s1_fire;

  // Output register.
  kmd_pkg::event_t out_ev;

  // Layer registers.
  logic [2:0] main_layer_reg;
  logic [7:0] active_layer_reg;

  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func   <= s_tuser;
      s1_item   <= in_item;
      s1_key_ok <= in_key_ok;
      s1_key    <= in_key;
    end
  end

  // Keymap: entry writes happen on acceptance, in item order with the reads.
  logic [LAYERS-1:0][15:0] km_row;

  kmd_keymap #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .LAYERS (LAYERS)
  ) u_keymap (
    .clk      (clk),
    .wr_en    (in_accept && (s_tuser == kmd_pkg::FUNC_MAP) && in_map_ok),
    .wr_key   (in_key),
    .wr_layer (in_item.map_layer[LAYER_W-1:0]),
    .wr_data  ({in_item.map_kind, in_item.map_value}),
    .rd_en    (in_accept),
    .rd_key   (in_key),
    .rd_row   (km_row)
  );

  // Per-key cooldown and recorded layer, written back as the item leaves.
  kmd_pkg::key_state_t ks_rd;
  kmd_pkg::key_state_t ks_next;
  logic                ks_wr;

  assign ks_wr = s1_fire && (s1_func == kmd_pkg::FUNC_SAMPLE) && s1_key_ok;

  kmd_key_state #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_key_state (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_key  (in_key),
    .wr_en   (ks_wr),
    .wr_key  (s1_key),
    .wr_data (ks_next),
    .rd_data (ks_rd)
  );

  // Event logic.
  kmd_pkg::event_t ev;
  logic [2:0]      main_next;
  logic [7:0]      active_next;

  kmd_event_unit #(
    .LAYERS (LAYERS)
  ) u_event_unit (
    .func           (s1_func),
    .item           (s1_item),
    .in_range       (s1_key_ok),
    .ks             (ks_rd),
    .km_row         (km_row),
    .main_layer     (main_layer_reg),
    .active_layer   (active_layer_reg),
    .usb_present    (usb_present),
    .key_up_delay   (key_up_delay),
    .key_down_delay (key_down_delay),
    .ev             (ev),
    .ks_next        (ks_next),
    .main_next      (main_next),
    .active_next    (active_next)
  );

  // Layer state advances with each item leaving the event stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_layer_reg   <= '0;
      active_layer_reg <= '0;
    end else if (s1_fire) begin
      main_layer_reg   <= main_next;
      active_layer_reg <= active_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ev <= ev;
    end
  end

  assign m_tuser = out_ev.event_res;
  assign m_tdata = {(kmd_pkg::M_TDATA_W - kmd_pkg::OUT_W)'(0), out_ev.data};

  // The main layer never leaves the configured range.
  a_main_in_range: assert property (@(posedge clk) disable iff (rst)
    4'(main_layer_reg) < 4'(LAYERS))
    else $error("main layer out of range");

  // A HID action only comes with a registered event.
  a_hid_has_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_ev.data.hid_action != kmd_pkg::HID_NONE) |->
    (out_ev.event_res != kmd_pkg::RES_NONE))
    else $error("HID action without an event");

  // An item leaving the event stage is offered on the output next cycle.
  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_tvalid)
    else $error("result item lost after the event stage");

  // A new item only enters an occupied event stage when that stage moves on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_accept && s1_valid |-> s1_fire)
    else $error("event stage overwritten");

endmodule

FILE: tb/sv/key_matrix_debounce_layer_engine_tb.sv
module key_matrix_debounce_layer_engine_tb;

  localparam int ROWS        = kmd_pkg::DEF_ROWS;
  localparam int COLS        = kmd_pkg::DEF_COLS;
  localparam int LAYERS      = kmd_pkg::DEF_LAYERS;
  localparam int NKEYS       = ROWS * COLS;
  localparam int ITEMS_PHASE = 57;
  localparam int DRAIN       = 6;
  localparam int STALL_LIMIT = 2000;

  // Keys that most samples go to, so that presses and releases follow each
  // other; each slot is a 7-bit key number {row, col}.
  localparam logic [41:0] KEY_POOL = {7'd28, 7'd83, 7'd69, 7'd58, 7'd127, 7'd0};

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [kmd_pkg::S_TDATA_W-1:0]   s_tdata = '0;
  logic                            s_tuser = kmd_pkg::FUNC_SAMPLE;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [kmd_pkg::M_TDATA_W-1:0]   m_tdata;
  logic [1:0]                      m_tuser;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [kmd_pkg::ADDR_W-1:0]      paddr = '0;
  logic [31:0]                     pwdata = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int stall_cnt = 0;

  // Tracks the debounce state, the keymap and both layers, and holds the
  // result items still owed by the block.
  class key_event_tracker;
    logic              usb_on;
    logic [7:0]        up_dly;
    logic [7:0]        down_dly;
    logic [7:0]        cool [NKEYS];
    logic [7:0]        press_lyr [NKEYS];
    logic [15:0]       keymap [LAYERS * NKEYS];
    bit                written [LAYERS * NKEYS];
    logic [2:0]        main_lyr;
    logic [7:0]        act_lyr;
    kmd_pkg::event_t   due_events [$];
    int                errors;

    function new();
      usb_on = kmd_pkg::RST_USB_PRESENT;
      up_dly = kmd_pkg::RST_KEY_UP;
      down_dly = kmd_pkg::RST_KEY_DOWN;
      foreach (cool[k]) begin
        cool[k] = '0;
        press_lyr[k] = '0;
      end
      foreach (keymap[k]) begin
        keymap[k] = '0;
        written[k] = 1'b0;
      end
      main_lyr = '0;
      act_lyr = '0;
      errors = 0;
    endfunction

    function void set_config(logic usb, logic [7:0] up, logic [7:0] dn);
      usb_on = usb;
      up_dly = up;
      down_dly = dn;
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    // Lookups above the last layer read as an empty entry.
    function logic [15:0] read_entry(int key, logic [7:0] lyr);
      if (lyr >= LAYERS) return '0;
      return keymap[lyr * NKEYS + key];
    endfunction

    function void step_main(bit up);
      int m;
      m = int'(main_lyr);
      if (up) m++;
      else if (m == 0) m = LAYERS - 1;
      else m--;
      if (m >= LAYERS) m = 0;
      main_lyr = 3'(m);
    endfunction

    // Keymap slot that a sample would read while still unwritten, else -1.
    function int fill_index(kmd_pkg::item_t it);
      int key;
      logic [7:0] lyr;
      key = int'({it.row, it.col});
      lyr = act_lyr;
      if (it.scan_start && (main_lyr >= LAYERS || act_lyr >= LAYERS)) lyr = '0;
      if (it.key_down) begin
        if (cool[key] != 8'd0) return -1;
      end else begin
        if (cool[key] != kmd_pkg::COOL_MAX - up_dly) return -1;
        lyr = press_lyr[key];
      end
      if (lyr >= LAYERS || written[lyr * NKEYS + key]) return -1;
      return lyr * NKEYS + key;
    endfunction

    // Advance the state by one accepted item and queue the result it owes.
    function void take_item(logic func, kmd_pkg::item_t it);
      kmd_pkg::event_t exp;
      int              key;
      int              cur;
      int              tries;
      bit              hit;
      logic [7:0]      bitm;
      logic [7:0]      hold;
      logic [15:0]     ent;
      logic [1:0]      res;
      logic [1:0]      hid;
      res = kmd_pkg::RES_NONE;
      hid = kmd_pkg::HID_NONE;
      ent = '0;
      key = int'({it.row, it.col});
      hold = kmd_pkg::COOL_MAX - up_dly;

      // A scan start pulls layers that are out of range back to zero.
      if (it.scan_start && (main_lyr >= LAYERS || act_lyr >= LAYERS)) begin
        main_lyr = '0;
        act_lyr = '0;
      end

      if (func == kmd_pkg::FUNC_MAP) begin
        if (it.row < ROWS && it.col < COLS && it.map_layer < LAYERS) begin
          keymap[it.map_layer * NKEYS + key] = {it.map_kind, it.map_value};
          written[it.map_layer * NKEYS + key] = 1'b1;
        end
      end else if (it.row < ROWS && it.col < COLS) begin
        if (it.key_down) begin
          if (cool[key] == 8'd0) begin
            ent = read_entry(key, act_lyr);
            res = kmd_pkg::RES_PRESS;
            press_lyr[key] = act_lyr;
            if (usb_on) begin
              case (ent[15:8])
                kmd_pkg::KIND_HID: hid = kmd_pkg::HID_PRESS;
                kmd_pkg::KIND_FN: act_lyr = ent[7:0];
                kmd_pkg::KIND_MOVE: begin
                  if (ent[7:0] == kmd_pkg::MOVE_UP) begin
                    step_main(1'b1);
                  end else if (ent[7:0] == kmd_pkg::MOVE_DOWN) begin
                    step_main(1'b0);
                  end else begin
                    // Rotate to the next layer whose bit is set, wrapping.
                    cur = int'(main_lyr);
                    bitm = 8'(1 << main_lyr);
                    tries = 0;
                    hit = 1'b0;
                    while (!hit && tries < kmd_pkg::ROT_TRIES) begin
                      cur++;
                      bitm = bitm << 1;
                      if (bitm == 8'd0 || cur >= LAYERS) begin
                        cur = 0;
                        bitm = 8'd1;
                      end
                      hit = (ent[7:0] & bitm) != 8'd0;
                      tries++;
                    end
                    main_lyr = 3'(cur);
                  end
                end
                kmd_pkg::KIND_TOGGLE:
                  act_lyr = (act_lyr == ent[7:0]) ? 8'(main_lyr) : ent[7:0];
                default: ;
              endcase
            end
            cool[key] = kmd_pkg::COOL_MAX;
          end
        end else if (cool[key] == hold) begin
          ent = read_entry(key, press_lyr[key]);
          res = kmd_pkg::RES_RELEASE;
          if (usb_on) begin
            if (ent[15:8] == kmd_pkg::KIND_HID) hid = kmd_pkg::HID_RELEASE;
            else if (ent[15:8] == kmd_pkg::KIND_FN) act_lyr = 8'(main_lyr);
          end
          cool[key] = down_dly;
        end
        if (cool[key] != 8'd0 && cool[key] != hold) cool[key] = cool[key] - 8'd1;
      end

      exp = '0;
      exp.event_res = res;
      if (res != kmd_pkg::RES_NONE) begin
        exp.data.event_value = ent[7:0];
        exp.data.event_kind = ent[15:8];
        exp.data.event_row = it.row;
        exp.data.event_col = it.col;
      end
      exp.data.hid_action = hid;
      exp.data.main_layer = main_lyr;
      exp.data.active_layer = act_lyr;
      due_events.push_back(exp);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_event(logic [1:0] ures, logic [kmd_pkg::M_TDATA_W-1:0] td);
      kmd_pkg::event_t    exp;
      kmd_pkg::out_data_t got;
      got = kmd_pkg::out_data_t'(td[kmd_pkg::OUT_W-1:0]);
      if (due_events.size() == 0) begin
        $display("%0t: result item with none expected, event_res %0h", $time, ures);
        errors++;
        return;
      end
      exp = due_events.pop_front();
      check_field("event_res", 32'(exp.event_res), 32'(ures));
      check_field("event_value", 32'(exp.data.event_value), 32'(got.event_value));
      check_field("event_kind", 32'(exp.data.event_kind), 32'(got.event_kind));
      check_field("event_row", 32'(exp.data.event_row), 32'(got.event_row));
      check_field("event_col", 32'(exp.data.event_col), 32'(got.event_col));
      check_field("hid_action", 32'(exp.data.hid_action), 32'(got.hid_action));
      check_field("main_layer", 32'(exp.data.main_layer), 32'(got.main_layer));
      check_field("active_layer", 32'(exp.data.active_layer), 32'(got.active_layer));
    endfunction
  endclass

  key_event_tracker tracker;

  key_matrix_debounce_layer_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one item, with random gaps before it, and wait until it is taken.
  task automatic send(logic func, kmd_pkg::item_t it);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(kmd_pkg::S_TDATA_W - kmd_pkg::ITEM_W){1'b0}}, it};
    s_tuser <= func;
    do @(posedge clk); while (!s_tready);
    tracker.take_item(func, it);
  endtask

  task automatic put_entry(logic [2:0] row, logic [3:0] col, logic [2:0] lyr,
                           logic [15:0] entry);
    kmd_pkg::item_t it;
    it = kmd_pkg::item_t'(kmd_pkg::ITEM_W'($urandom));
    it.scan_start = ($urandom_range(7) == 0);
    it.row = row;
    it.col = col;
    it.map_layer = lyr;
    it.map_value = entry[7:0];
    it.map_kind = entry[15:8];
    send(kmd_pkg::FUNC_MAP, it);
  endtask

  // Entry contents, half HID keys, with layer keys and undefined kinds mixed in.
  function automatic logic [15:0] rand_entry();
    int         pick;
    logic [7:0] kind;
    logic [7:0] val;
    pick = $urandom_range(99);
    val = 8'($urandom_range(255));
    if (pick < 50) begin
      kind = kmd_pkg::KIND_HID;
    end else if (pick < 64) begin
      kind = kmd_pkg::KIND_FN;
      if ($urandom_range(4) != 0) val = 8'($urandom_range(LAYERS - 1));
    end else if (pick < 78) begin
      kind = kmd_pkg::KIND_MOVE;
      if ($urandom_range(2) == 0) val = kmd_pkg::MOVE_UP;
      else if ($urandom_range(1) == 0) val = kmd_pkg::MOVE_DOWN;
    end else if (pick < 90) begin
      kind = kmd_pkg::KIND_TOGGLE;
      if ($urandom_range(4) != 0) val = 8'($urandom_range(LAYERS - 1));
    end else begin
      kind = 8'($urandom_range(255, 4));
    end
    return {kind, val};
  endfunction

  // A key sample; any keymap entry it would read unwritten is written first.
  task automatic sample(logic [2:0] row, logic [3:0] col, logic down, logic scan);
    kmd_pkg::item_t it;
    int             fill;
    it = kmd_pkg::item_t'(kmd_pkg::ITEM_W'($urandom));
    it.scan_start = scan;
    it.row = row;
    it.col = col;
    it.key_down = down;
    fill = tracker.fill_index(it);
    while (fill >= 0) begin
      put_entry(3'((fill % NKEYS) / COLS), 4'(fill % COLS), 3'(fill / NKEYS),
                rand_entry());
      fill = tracker.fill_index(it);
    end
    send(kmd_pkg::FUNC_SAMPLE, it);
  endtask

  // Write all three registers back to back, then read each one back.
  task automatic write_settings(logic usb, logic [7:0] up, logic [7:0] dn);
    logic [1:0]  reg_idx [3];
    logic [31:0] vals [3];
    int          n;
    reg_idx[0] = kmd_pkg::REG_USB_PRESENT;
    reg_idx[1] = kmd_pkg::REG_KEY_UP;
    reg_idx[2] = kmd_pkg::REG_KEY_DOWN;
    vals[0] = {31'd0, usb};
    vals[1] = {24'd0, up};
    vals[2] = {24'd0, dn};
    for (n = 0; n < 6; n++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= (n < 3);
      paddr <= {reg_idx[n % 3], 2'b00};
      pwdata <= vals[n % 3];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (n >= 3 && prdata !== vals[n % 3]) begin
        $display("%0t: register %0d expected %0h actual %0h", $time, reg_idx[n % 3],
                 vals[n % 3], prdata);
        tracker.errors++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_config(usb, up, dn);
  endtask

  // Receiver side: random stalls at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_event(m_tuser, m_tdata);
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int         p;
    int         n;
    int         pick;
    int         slot;
    logic [6:0] key;
    logic       down;
    logic [5:0] held;
    logic       cfg_usb;
    logic [7:0] cfg_up;
    logic [7:0] cfg_dn;
    tracker = new();
    held = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (p = 0; p < 8; p++) begin
      // Settings per phase, with the stuck-cooldown pairs among them.
      case (p)
        0: begin cfg_usb = 1'b1; cfg_up = 8'd5;   cfg_dn = 8'd5;   end
        1: begin cfg_usb = 1'b1; cfg_up = 8'd0;   cfg_dn = 8'd0;   end
        2: begin cfg_usb = 1'b0; cfg_up = 8'd2;   cfg_dn = 8'd3;   end
        3: begin cfg_usb = 1'b1; cfg_up = 8'd255; cfg_dn = 8'd0;   end
        4: begin cfg_usb = 1'b1; cfg_up = 8'd1;   cfg_dn = 8'd255; end
        5: begin cfg_usb = 1'b1; cfg_up = 8'd250; cfg_dn = 8'd5;   end
        6: begin cfg_usb = 1'b1; cfg_up = 8'd3;   cfg_dn = 8'd2;   end
        default: begin cfg_usb = 1'b1; cfg_up = 8'd7; cfg_dn = 8'd1; end
      endcase

      // Let the block go idle before touching its registers.
      while (tracker.pending() != 0) @(posedge clk);
      repeat (DRAIN) @(posedge clk);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
        default: begin src_idle_pct = 15; snk_stall_pct = 15; end
      endcase
      write_settings(cfg_usb, cfg_up, cfg_dn);

      if (p == 0) begin
        // Directed: every kind of key, both layer wraps, a rotate, a toggle
        // to a layer out of range, a lookup there and the scan start reset.
        put_entry(3'd0, 4'd0, 3'd0, {kmd_pkg::KIND_HID, 8'hA5});
        put_entry(3'd7, 4'd15, 3'd0, {kmd_pkg::KIND_FN, 8'd3});
        put_entry(3'd1, 4'd1, 3'd3, {kmd_pkg::KIND_MOVE, kmd_pkg::MOVE_UP});
        put_entry(3'd2, 4'd2, 3'd3, {kmd_pkg::KIND_MOVE, kmd_pkg::MOVE_DOWN});
        put_entry(3'd3, 4'd3, 3'd3, {kmd_pkg::KIND_MOVE, 8'h81});
        put_entry(3'd4, 4'd4, 3'd3, {kmd_pkg::KIND_TOGGLE, 8'd9});
        put_entry(3'd5, 4'd5, 3'd3, {8'hFF, 8'hFF});
        sample(3'd0, 4'd0, 1'b1, 1'b1);
        sample(3'd7, 4'd15, 1'b1, 1'b0);
        sample(3'd2, 4'd2, 1'b1, 1'b0);
        sample(3'd1, 4'd1, 1'b1, 1'b0);
        sample(3'd3, 4'd3, 1'b1, 1'b0);
        sample(3'd5, 4'd5, 1'b1, 1'b0);
        sample(3'd4, 4'd4, 1'b1, 1'b0);
        sample(3'd6, 4'd6, 1'b1, 1'b0);
        sample(3'd6, 4'd6, 1'b0, 1'b1);
        repeat (5) sample(3'd0, 4'd0, 1'b0, 1'b0);
      end

      // Random part: held keys from a small set, stray keys and entry rewrites.
      for (n = 0; n < ITEMS_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          if ($urandom_range(9) < 7) key = KEY_POOL[$urandom_range(5) * 7 +: 7];
          else key = 7'($urandom_range(NKEYS - 1));
          put_entry(key[6:4], key[3:0], 3'($urandom_range(LAYERS - 1)), rand_entry());
        end else begin
          if ($urandom_range(4) != 0) begin
            slot = $urandom_range(5);
            key = KEY_POOL[slot * 7 +: 7];
            if ($urandom_range(99) < 30) held[slot] = ~held[slot];
            down = held[slot];
          end else begin
            key = 7'($urandom_range(NKEYS - 1));
            down = 1'($urandom_range(1));
          end
          sample(key[6:4], key[3:0], down, $urandom_range(7) == 0);
        end
      end
      s_tvalid <= 1'b0;
    end

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
